FILE: rtl/bttb_pkg.sv
// ----------------------------------------------------------------------------
// bttb_pkg
// shared constants, types and helpers of the bilinear texel tint blend unit
// ----------------------------------------------------------------------------
`default_nettype none

package bttb_pkg;

  // texture geometry
  localparam int TexBits   = 6;
  localparam int TEX_SIDE  = 1 << TexBits;
  localparam int BankBits  = 2 * (TexBits - 1);
  localparam int BankDepth = 1 << BankBits;
  localparam int IdxW      = 2 * TexBits;

  // screen coordinates
  localparam int CoordBits = 12;
  localparam int OrgW      = CoordBits + 1;
  localparam int StepW     = 16;
  localparam int DimW      = 7;
  localparam int ClipW     = 4 * CoordBits;
  localparam int TintW     = 36;

  // configuration port
  localparam int CfgAw = 6;
  localparam int CfgDw = 64;

  localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [2:0] REG_STEP_X     = 3'd2;
  localparam logic [2:0] REG_STEP_Y     = 3'd3;
  localparam logic [2:0] REG_TEX_WIDTH  = 3'd4;
  localparam logic [2:0] REG_TEX_HEIGHT = 3'd5;
  localparam logic [2:0] REG_CLIP_RECT  = 3'd6;
  localparam logic [2:0] REG_TINT_RGBA  = 3'd7;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SHADE = 1'b1;

  typedef logic [31:0] texel_t;

  // control that travels with every request down the pipe
  typedef struct packed {
    logic   vld;
    logic   cov;
    texel_t dest;
  } ctl_t;

  function automatic logic [DimW-1:0] dim_in_use(input logic [DimW-1:0] v);
    logic [DimW-1:0] d;
    d = v;
    if (v < DimW'(3)) d = DimW'(3);
    else if (v > DimW'(TEX_SIDE)) d = DimW'(TEX_SIDE);
    return d;
  endfunction

  function automatic logic [8:0] tint_clamp(input logic [8:0] t);
    return (t > 9'd256) ? 9'd256 : t;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bilinear_texel_tint_blend_unit.sv
// ----------------------------------------------------------------------------
// bilinear_texel_tint_blend_unit
// textured quad pixel shader: bilinear sample, tint, premultiplied over blend
// ----------------------------------------------------------------------------
// path: a request runs through the map, filter and blend stages to the output register
// throughput: one request per cycle; the whole pipe moves on one enable and
//   holds while the output register is full and not taken
// reset: synchronous active-low rst_n clears the stage valid bits and loads
//   the register reset values; texture contents stay undefined until loaded
`default_nettype none

module bilinear_texel_tint_blend_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // request stream
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // texel_index, texel_value, pixel_x, pixel_y, dest_pixel, 4 zero bits
  input  wire logic [103:0]                 in_tdata,
  // opcode
  input  wire logic [0:0]                   in_tuser,
  // result stream
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // pixel_value
  output logic [31:0]                       out_tdata,
  // pixel_write
  output logic [0:0]                        out_tuser,
  // register port
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [bttb_pkg::CfgAw-1:0]   cfg_paddr,
  input  wire logic [bttb_pkg::CfgDw-1:0]   cfg_pwdata,
  output logic [bttb_pkg::CfgDw-1:0]        cfg_prdata,
  output logic                              cfg_pready
);
  import bttb_pkg::*;

  // configuration registers
  logic [OrgW-1:0]  origin_x_r, origin_y_r;
  logic [StepW-1:0] step_x_r, step_y_r;
  logic [DimW-1:0]  tex_width_r, tex_height_r;
  logic [ClipW-1:0] clip_rect_r;
  logic [TintW-1:0] tint_rgba_r;
  logic [2:0]       cfg_idx;
  logic             cfg_wr;

  // pipe control
  logic   adv;
  logic   in_fire;
  logic   shade;
  ctl_t   map_ctl, flt_ctl;
  logic [TexBits-1:0] nx, ny;
  logic [7:0]   fx, fy;
  texel_t       tex [4];
  logic [23:0]  sums [4];
  logic         out_write;

  // load requests ride along with the first two stages
  logic            ld1_r, ld2_r;
  logic [IdxW-1:0] ld_idx1_r, ld_idx2_r;
  texel_t          ld_dat1_r, ld_dat2_r;

  // the pipe moves whenever the output register is free or being emptied
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign in_fire   = in_tvalid && adv;
  assign shade     = (in_tuser[0] == OP_SHADE);

  // register writes complete on the access phase, pready tied high
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CfgAw-1:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      step_x_r     <= '0;
      step_y_r     <= '0;
      tex_width_r  <= DimW'(3);
      tex_height_r <= DimW'(3);
      clip_rect_r  <= '0;
      tint_rgba_r  <= '1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ORIGIN_X:   origin_x_r   <= cfg_pwdata[OrgW-1:0];
        REG_ORIGIN_Y:   origin_y_r   <= cfg_pwdata[OrgW-1:0];
        REG_STEP_X:     step_x_r     <= cfg_pwdata[StepW-1:0];
        REG_STEP_Y:     step_y_r     <= cfg_pwdata[StepW-1:0];
        REG_TEX_WIDTH:  tex_width_r  <= cfg_pwdata[DimW-1:0];
        REG_TEX_HEIGHT: tex_height_r <= cfg_pwdata[DimW-1:0];
        REG_CLIP_RECT:  clip_rect_r  <= cfg_pwdata[ClipW-1:0];
        REG_TINT_RGBA:  tint_rgba_r  <= cfg_pwdata[TintW-1:0];
        default: ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    case (cfg_idx)
      REG_ORIGIN_X:   cfg_prdata = CfgDw'(origin_x_r);
      REG_ORIGIN_Y:   cfg_prdata = CfgDw'(origin_y_r);
      REG_STEP_X:     cfg_prdata = CfgDw'(step_x_r);
      REG_STEP_Y:     cfg_prdata = CfgDw'(step_y_r);
      REG_TEX_WIDTH:  cfg_prdata = CfgDw'(tex_width_r);
      REG_TEX_HEIGHT: cfg_prdata = CfgDw'(tex_height_r);
      REG_CLIP_RECT:  cfg_prdata = CfgDw'(clip_rect_r);
      REG_TINT_RGBA:  cfg_prdata = CfgDw'(tint_rgba_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // stages 1-2: clip, origin offset, step multiply, coverage
  bttb_map u_map (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_vld     (in_fire),
    .shade      (shade),
    .px         (in_tdata[55:44]),
    .py         (in_tdata[67:56]),
    .dest       (in_tdata[99:68]),
    .origin_x   (origin_x_r),
    .origin_y   (origin_y_r),
    .step_x     (step_x_r),
    .step_y     (step_y_r),
    .tex_width  (tex_width_r),
    .tex_height (tex_height_r),
    .clip_rect  (clip_rect_r),
    .ctl_o      (map_ctl),
    .nx_o       (nx),
    .ny_o       (ny),
    .fx_o       (fx),
    .fy_o       (fy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld1_r <= 1'b0;
      ld2_r <= 1'b0;
    end else if (adv) begin
      ld1_r <= in_fire && !shade;
      ld2_r <= ld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ld_idx1_r <= in_tdata[IdxW-1:0];
      ld_dat1_r <= in_tdata[43:12];
      ld_idx2_r <= ld_idx1_r;
      ld_dat2_r <= ld_dat1_r;
    end
  end

  // a load is written as it leaves stage 2, the same edge at which a shade
  // request in that slot would read its 2x2 block, so loads and reads stay
  // in request order
  bttb_tex_mem u_mem (
    .clk   (clk),
    .we    (ld2_r && adv),
    .waddr (ld_idx2_r),
    .wdata (ld_dat2_r),
    .re    (adv),
    .rx    (nx),
    .ry    (ny),
    .tex_o (tex)
  );

  // stages 3-5: weights and weighted sums per channel
  bttb_filter u_flt (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .ctl_i (map_ctl),
    .fx    (fx),
    .fy    (fy),
    .tex   (tex),
    .ctl_o (flt_ctl),
    .sum_o (sums)
  );

  // stages 6-11: tint, blend numerators, divide by 255*2^32, output register
  bttb_blend u_bld (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .ctl_i     (flt_ctl),
    .sum_i     (sums),
    .tint_rgba (tint_rgba_r),
    .out_vld   (out_tvalid),
    .out_write (out_write),
    .out_value (out_tdata)
  );

  assign out_tuser = out_write;

endmodule

`default_nettype wire

FILE: rtl/bttb_map.sv
// ----------------------------------------------------------------------------
// bttb_map
// clip test, screen to texel mapping and coverage test
// ----------------------------------------------------------------------------
`default_nettype none

module bttb_map (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                adv,
  input  wire logic                                in_vld,
  input  wire logic                                shade,
  input  wire logic [bttb_pkg::CoordBits-1:0]      px,
  input  wire logic [bttb_pkg::CoordBits-1:0]      py,
  input  wire logic [31:0]                         dest,
  input  wire logic [bttb_pkg::OrgW-1:0]           origin_x,
  input  wire logic [bttb_pkg::OrgW-1:0]           origin_y,
  input  wire logic [bttb_pkg::StepW-1:0]          step_x,
  input  wire logic [bttb_pkg::StepW-1:0]          step_y,
  input  wire logic [bttb_pkg::DimW-1:0]           tex_width,
  input  wire logic [bttb_pkg::DimW-1:0]           tex_height,
  input  wire logic [bttb_pkg::ClipW-1:0]          clip_rect,
  output bttb_pkg::ctl_t                           ctl_o,
  output logic [bttb_pkg::TexBits-1:0]             nx_o,
  output logic [bttb_pkg::TexBits-1:0]             ny_o,
  output logic [7:0]                               fx_o,
  output logic [7:0]                               fy_o
);
  import bttb_pkg::*;

  localparam int ProdW = OrgW + StepW;

  logic              clip_ok;
  logic [OrgW:0]     dx, dy;
  ctl_t              ctl1_nxt, ctl1_r, ctl2_r;
  logic [OrgW-1:0]   dx1_r, dy1_r;
  logic [ProdW-1:0]  tx2_r, ty2_r;
  logic [TexBits-1:0] dxm2, dym2;
  logic [ProdW-1:0]  lim_x, lim_y;

  // stage 1: clip and offset from the quad origin
  always_comb begin
    clip_ok = (px >= clip_rect[0 +: CoordBits]) && (py >= clip_rect[CoordBits +: CoordBits])
           && (px <  clip_rect[2*CoordBits +: CoordBits])
           && (py <  clip_rect[3*CoordBits +: CoordBits]);
    dx = {2'b00, px} - {origin_x[OrgW-1], origin_x};
    dy = {2'b00, py} - {origin_y[OrgW-1], origin_y};
    ctl1_nxt.vld  = in_vld;
    ctl1_nxt.cov  = shade && clip_ok && !dx[OrgW] && !dy[OrgW];
    ctl1_nxt.dest = shade ? dest : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.vld <= 1'b0;
      ctl2_r.vld <= 1'b0;
    end else if (adv) begin
      ctl1_r.vld <= ctl1_nxt.vld;
      ctl2_r.vld <= ctl1_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl1_r.cov  <= ctl1_nxt.cov;
      ctl1_r.dest <= ctl1_nxt.dest;
      dx1_r       <= dx[OrgW-1:0];
      dy1_r       <= dy[OrgW-1:0];
      // stage 2: scale into texel space, 16 fraction bits
      ctl2_r.cov  <= ctl1_r.cov;
      ctl2_r.dest <= ctl1_r.dest;
      tx2_r       <= ProdW'(dx1_r) * ProdW'(step_x);
      ty2_r       <= ProdW'(dy1_r) * ProdW'(step_y);
    end
  end

  // coverage against the last usable texel pair
  always_comb begin
    dxm2  = TexBits'(dim_in_use(tex_width) - DimW'(2));
    dym2  = TexBits'(dim_in_use(tex_height) - DimW'(2));
    lim_x = ProdW'({dxm2, 16'h0000});
    lim_y = ProdW'({dym2, 16'h0000});
    ctl_o.vld  = ctl2_r.vld;
    ctl_o.cov  = ctl2_r.cov && (tx2_r <= lim_x) && (ty2_r <= lim_y);
    ctl_o.dest = ctl2_r.dest;
    nx_o = tx2_r[16 +: TexBits];
    ny_o = ty2_r[16 +: TexBits];
    fx_o = tx2_r[15:8];
    fy_o = ty2_r[15:8];
  end

endmodule

`default_nettype wire

FILE: rtl/bttb_tex_mem.sv
// ----------------------------------------------------------------------------
// bttb_tex_mem
// texture store in four banks by row and column parity, 2x2 read per cycle while re is high
// ----------------------------------------------------------------------------
`default_nettype none

module bttb_tex_mem (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [bttb_pkg::IdxW-1:0]      waddr,
  input  wire logic [31:0]                    wdata,
  input  wire logic                           re,
  input  wire logic [bttb_pkg::TexBits-1:0]   rx,
  input  wire logic [bttb_pkg::TexBits-1:0]   ry,
  output bttb_pkg::texel_t                    tex_o [4]
);
  import bttb_pkg::*;

  texel_t     bank_q [4];
  logic       px0_r, py0_r;
  logic [TexBits-1:0] wrow, wcol;

  assign wrow = waddr[IdxW-1 -: TexBits];
  assign wcol = waddr[TexBits-1:0];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    texel_t             mem [BankDepth];
    texel_t             q_r;
    logic [TexBits:0]   rrow, rcol;
    logic [BankBits-1:0] ra, wa;

    // neighbour that falls into this bank
    assign rrow = {1'b0, ry} + (TexBits+1)'(ry[0] ^ b[1]);
    assign rcol = {1'b0, rx} + (TexBits+1)'(rx[0] ^ b[0]);
    assign ra   = {rrow[TexBits-1:1], rcol[TexBits-1:1]};
    assign wa   = {wrow[TexBits-1:1], wcol[TexBits-1:1]};

    always_ff @(posedge clk) begin
      if (we && (wrow[0] == b[1]) && (wcol[0] == b[0])) mem[wa] <= wdata;
      if (re) q_r <= mem[ra];
    end

    assign bank_q[b] = q_r;
  end

  always_ff @(posedge clk) begin
    if (re) begin
      px0_r <= rx[0];
      py0_r <= ry[0];
    end
  end

  // order: top-left, top-right, bottom-left, bottom-right
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      tex_o[i] = bank_q[{py0_r ^ i[1], px0_r ^ i[0]}];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bttb_filter.sv
// ----------------------------------------------------------------------------
// bttb_filter
// bilinear weights and weighted channel sums
// ----------------------------------------------------------------------------
`default_nettype none

module bttb_filter (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           adv,
  input  bttb_pkg::ctl_t                      ctl_i,
  input  wire logic [7:0]                     fx,
  input  wire logic [7:0]                     fy,
  input  bttb_pkg::texel_t                    tex [4],
  output bttb_pkg::ctl_t                      ctl_o,
  output logic [23:0]                         sum_o [4]
);
  import bttb_pkg::*;

  ctl_t        ctl3_r, ctl4_r, ctl5_r;
  logic [7:0]  fx3_r, fy3_r;
  logic [8:0]  wx [2];
  logic [8:0]  wy [2];
  logic [16:0] w_nxt [4];
  logic [16:0] w4_r [4];
  texel_t      tex4_r [4];
  logic [24:0] acc [4];
  logic [23:0] sum5_r [4];

  always_comb begin
    wx[0] = 9'd256 - {1'b0, fx3_r};
    wx[1] = {1'b0, fx3_r};
    wy[0] = 9'd256 - {1'b0, fy3_r};
    wy[1] = {1'b0, fy3_r};
    for (int i = 0; i < 4; i++) begin
      w_nxt[i] = 17'(18'(wx[i%2]) * 18'(wy[i/2]));
    end
    // lane k is byte k of the texel: blue, green, red, alpha
    for (int k = 0; k < 4; k++) begin
      acc[k] = '0;
      for (int i = 0; i < 4; i++) begin
        acc[k] = acc[k] + 25'(w4_r[i]) * 25'(tex4_r[i][8*k +: 8]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r.vld <= 1'b0;
      ctl4_r.vld <= 1'b0;
      ctl5_r.vld <= 1'b0;
    end else if (adv) begin
      ctl3_r.vld <= ctl_i.vld;
      ctl4_r.vld <= ctl3_r.vld;
      ctl5_r.vld <= ctl4_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl3_r.cov  <= ctl_i.cov;
      ctl3_r.dest <= ctl_i.dest;
      fx3_r       <= fx;
      fy3_r       <= fy;
      ctl4_r.cov  <= ctl3_r.cov;
      ctl4_r.dest <= ctl3_r.dest;
      ctl5_r.cov  <= ctl4_r.cov;
      ctl5_r.dest <= ctl4_r.dest;
      for (int i = 0; i < 4; i++) begin
        w4_r[i]   <= w_nxt[i];
        tex4_r[i] <= tex[i];
        sum5_r[i] <= acc[i][23:0];
      end
    end
  end

  assign ctl_o = ctl5_r;
  assign sum_o = sum5_r;

endmodule

`default_nettype wire

FILE: rtl/bttb_blend.sv
// ----------------------------------------------------------------------------
// bttb_blend
// tint, premultiplied over blend, rounding divide and output register
// ----------------------------------------------------------------------------
`default_nettype none

module bttb_blend (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  bttb_pkg::ctl_t                   ctl_i,
  input  wire logic [23:0]                 sum_i [4],
  input  wire logic [bttb_pkg::TintW-1:0]  tint_rgba,
  output logic                             out_vld,
  output logic                             out_write,
  output logic [31:0]                      out_value
);
  import bttb_pkg::*;

  localparam int SaW  = 41;
  localparam int NumW = 50;
  localparam int MW   = 19;
  localparam logic [SaW-1:0]  DEN  = SaW'(255) << 32;
  localparam logic [NumW:0]   HALF = (NumW+1)'(255) << 31;

  ctl_t          ctl6_r, ctl7_r, ctl8_r, ctl9_r, ctl10_r, ctl11_r;
  logic [8:0]    tint_r [4];
  logic [16:0]   tsq_r;
  logic [SaW-1:0] sa_full, sa6_r, inv7_r;
  logic [32:0]   sct6_r [3];
  logic [NumW-1:0] sa255_7_r;
  logic [NumW-1:0] sc255_7_r [3];
  logic [NumW-1:0] num8_r [4];
  logic [NumW:0]   rnd [4];
  logic [MW-1:0] m9_r [4];
  logic [MW-1:0] m10_r [4];
  logic [11:0]   q0_10_r [4];
  logic [MW-1:0] rem [4];
  logic [11:0]   q [4];
  logic [31:0]   res;
  logic [31:0]   value_r;

  // tint per lane: blue, green, red from fields 2, 1, 0; alpha from field 3
  always_ff @(posedge clk) begin
    tint_r[0] <= tint_clamp(tint_rgba[18 +: 9]);
    tint_r[1] <= tint_clamp(tint_rgba[9 +: 9]);
    tint_r[2] <= tint_clamp(tint_rgba[0 +: 9]);
    tint_r[3] <= tint_clamp(tint_rgba[27 +: 9]);
    tsq_r     <= 17'(18'(tint_r[3]) * 18'(tint_r[3]));
  end

  always_comb begin
    sa_full = SaW'(sum_i[3]) * SaW'(tsq_r);
    for (int k = 0; k < 4; k++) begin
      rnd[k] = (NumW+1)'(num8_r[k]) + HALF;
      // floor divide by 255 after the first estimate
      rem[k] = m10_r[k] - ((MW'(q0_10_r[k]) << 8) - MW'(q0_10_r[k]));
      q[k]   = q0_10_r[k] + ((rem[k] >= MW'(255)) ? 12'd1 : 12'd0);
      res[8*k +: 8] = (q[k] > 12'd255) ? 8'hff : q[k][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl6_r.vld  <= 1'b0;
      ctl7_r.vld  <= 1'b0;
      ctl8_r.vld  <= 1'b0;
      ctl9_r.vld  <= 1'b0;
      ctl10_r.vld <= 1'b0;
      ctl11_r.vld <= 1'b0;
    end else if (adv) begin
      ctl6_r.vld  <= ctl_i.vld;
      ctl7_r.vld  <= ctl6_r.vld;
      ctl8_r.vld  <= ctl7_r.vld;
      ctl9_r.vld  <= ctl8_r.vld;
      ctl10_r.vld <= ctl9_r.vld;
      ctl11_r.vld <= ctl10_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl6_r.cov   <= ctl_i.cov;    ctl6_r.dest  <= ctl_i.dest;
      ctl7_r.cov   <= ctl6_r.cov;   ctl7_r.dest  <= ctl6_r.dest;
      ctl8_r.cov   <= ctl7_r.cov;   ctl8_r.dest  <= ctl7_r.dest;
      ctl9_r.cov   <= ctl8_r.cov;   ctl9_r.dest  <= ctl8_r.dest;
      ctl10_r.cov  <= ctl9_r.cov;   ctl10_r.dest <= ctl9_r.dest;
      ctl11_r.cov  <= ctl10_r.cov;  ctl11_r.dest <= ctl10_r.dest;
      // source coverage, tint alpha twice
      sa6_r <= (sa_full > DEN) ? DEN : sa_full;
      for (int k = 0; k < 3; k++) begin
        sct6_r[k]    <= 33'(sum_i[k]) * 33'(tint_r[k]);
        sc255_7_r[k] <= ((NumW'(sct6_r[k]) << 8) - NumW'(sct6_r[k])) << 8;
      end
      inv7_r    <= DEN - sa6_r;
      sa255_7_r <= (NumW'(sa6_r) << 8) - NumW'(sa6_r);
      for (int k = 0; k < 4; k++) begin
        num8_r[k] <= NumW'(NumW'(ctl7_r.dest[8*k +: 8]) * NumW'(inv7_r))
                   + ((k == 3) ? sa255_7_r : sc255_7_r[k%3]);
        m9_r[k]    <= MW'(rnd[k] >> 32);
        m10_r[k]   <= m9_r[k];
        q0_10_r[k] <= 12'((28'(m9_r[k]) * 28'(257)) >> 16);
      end
      value_r <= ctl10_r.cov ? res : ctl10_r.dest;
    end
  end

  assign out_vld   = ctl11_r.vld;
  assign out_write = ctl11_r.cov;
  assign out_value = value_r;

endmodule

`default_nettype wire

FILE: sim/bttb_checker.sv
// ----------------------------------------------------------------------------
// bttb_checker
// watches the request, result and register ports of the shader, predicts
// every result from its own copy of the texture and registers, and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bttb_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [103:0] in_tdata,
  input  wire logic [0:0]   in_tuser,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [31:0]  out_tdata,
  input  wire logic [0:0]   out_tuser,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [5:0]   cfg_paddr,
  input  wire logic [63:0]  cfg_pwdata,
  input  wire logic         cfg_pready,
  output int                fail_count,
  output int                pending,
  output int                covered_count,
  output int                shade_count
);
  import bttb_pkg::*;

  typedef struct packed {
    logic        wr;
    logic [31:0] value;
  } pixel_res_t;

  logic [31:0]     texel_mem [TEX_SIDE*TEX_SIDE];
  logic [12:0]     org_x, org_y;
  logic [15:0]     step_x, step_y;
  logic [6:0]      width_reg, height_reg;
  logic [47:0]     clip_reg;
  logic [35:0]     tint_reg;
  pixel_res_t      pixel_expect [$];

  function automatic int dim_clamp(logic [6:0] v);
    int d;
    d = v;
    if (d < 3) d = 3;
    if (d > TEX_SIDE) d = TEX_SIDE;
    return d;
  endfunction

  function automatic logic [63:0] tint_ch(int k);
    logic [63:0] t;
    t = (tint_reg >> (9 * k)) & 36'h1ff;
    return (t > 256) ? 64'd256 : t;
  endfunction

  function automatic bit texel_coord(int pix, logic [12:0] org, logic [15:0] step,
                                     int dim, output int whole, output int frac);
    int d;
    logic [63:0] t;
    d = pix - int'($signed(org));
    whole = 0;
    frac = 0;
    if (d < 0) return 0;
    t = 64'(d) * 64'(step);
    if (t > (64'(dim - 2) << 16)) return 0;
    whole = int'(t >> 16);
    frac = int'((t >> 8) & 64'hff);
    return 1;
  endfunction

  function automatic logic [31:0] round_sat(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    q = (num + den / 2) / den;
    return (q > 255) ? 32'd255 : q[31:0];
  endfunction

  function automatic pixel_res_t shade_pixel(logic [11:0] px, logic [11:0] py,
                                             logic [31:0] dest);
    pixel_res_t  r;
    int          nx, ny, fx, fy, sh;
    logic [31:0] tex [4];
    logic [63:0] wgt [4];
    logic [63:0] den, sa, sum, dc, num;
    den = 64'd255 << 32;
    r.wr = 1'b0;
    r.value = dest;
    if (px < clip_reg[11:0] || py < clip_reg[23:12] ||
        px >= clip_reg[35:24] || py >= clip_reg[47:36]) return r;
    if (!texel_coord(int'(px), org_x, step_x, dim_clamp(width_reg), nx, fx)) return r;
    if (!texel_coord(int'(py), org_y, step_y, dim_clamp(height_reg), ny, fy)) return r;
    tex[0] = texel_mem[ny * TEX_SIDE + nx];
    tex[1] = texel_mem[ny * TEX_SIDE + nx + 1];
    tex[2] = texel_mem[(ny + 1) * TEX_SIDE + nx];
    tex[3] = texel_mem[(ny + 1) * TEX_SIDE + nx + 1];
    wgt[0] = 64'((256 - fx) * (256 - fy));
    wgt[1] = 64'(fx * (256 - fy));
    wgt[2] = 64'((256 - fx) * fy);
    wgt[3] = 64'(fx * fy);
    // source coverage takes the tint alpha twice
    sum = 0;
    for (int i = 0; i < 4; i++) sum += wgt[i] * 64'(tex[i][31:24]);
    sa = sum * tint_ch(3) * tint_ch(3);
    if (sa > den) sa = den;
    r.value = round_sat(64'd255 * sa + 64'(dest[31:24]) * (den - sa), den) << 24;
    for (int k = 0; k < 3; k++) begin
      sh = 16 - 8 * k;
      dc = (dest >> sh) & 32'hff;
      sum = 0;
      for (int i = 0; i < 4; i++) sum += wgt[i] * ((tex[i] >> sh) & 32'hff);
      num = dc * (den - sa) + sum * tint_ch(k) * 64'd255 * 64'd256;
      r.value |= round_sat(num, den) << sh;
    end
    r.wr = 1'b1;
    return r;
  endfunction

  assign pending = pixel_expect.size();

  always @(posedge clk) begin
    pixel_res_t e;
    if (!rst_n) begin
      org_x <= '0;
      org_y <= '0;
      step_x <= '0;
      step_y <= '0;
      width_reg <= 7'd3;
      height_reg <= 7'd3;
      clip_reg <= '0;
      tint_reg <= '1;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[5:3])
          REG_ORIGIN_X:   org_x <= cfg_pwdata[12:0];
          REG_ORIGIN_Y:   org_y <= cfg_pwdata[12:0];
          REG_STEP_X:     step_x <= cfg_pwdata[15:0];
          REG_STEP_Y:     step_y <= cfg_pwdata[15:0];
          REG_TEX_WIDTH:  width_reg <= cfg_pwdata[6:0];
          REG_TEX_HEIGHT: height_reg <= cfg_pwdata[6:0];
          REG_CLIP_RECT:  clip_reg <= cfg_pwdata[47:0];
          REG_TINT_RGBA:  tint_reg <= cfg_pwdata[35:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == OP_LOAD) begin
          texel_mem[in_tdata[11:0]] = in_tdata[43:12];
          pixel_expect.push_back('{wr: 1'b0, value: 32'd0});
        end else begin
          e = shade_pixel(in_tdata[55:44], in_tdata[67:56], in_tdata[99:68]);
          shade_count++;
          if (e.wr) covered_count++;
          pixel_expect.push_back(e);
        end
      end
      if (out_tvalid && out_tready) begin
        if (pixel_expect.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: write %0d value %08h", out_tuser[0], out_tdata);
        end else begin
          e = pixel_expect.pop_front();
          if (e.wr !== out_tuser[0] || e.value !== out_tdata) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected write %0d value %08h, got write %0d value %08h",
                       e.wr, e.value, out_tuser[0], out_tdata);
          end
        end
      end
    end
  end

  initial begin
    fail_count = 0;
    covered_count = 0;
    shade_count = 0;
  end

endmodule

FILE: sim/tb_bilinear_texel_tint_blend_unit.sv
// ----------------------------------------------------------------------------
// tb_bilinear_texel_tint_blend_unit
// drives texel loads, pixel shades and register writes into the shader under
// random stalls on both streams; the checker beside it predicts and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_bilinear_texel_tint_blend_unit;
  import bttb_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;    // texel_index, texel_value, pixel_x, pixel_y, dest_pixel
  logic [0:0]   in_tuser;    // opcode
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;   // pixel_value
  logic [0:0]   out_tuser;   // pixel_write
  logic         cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [5:0]   cfg_paddr;
  logic [63:0]  cfg_pwdata, cfg_prdata;
  int           fail_count, pending, covered_count, shade_count;

  // shadow of the registers, only used to aim the pixels
  int           ox, oy, sx, sy, wd, ht;
  bit           written [TEX_SIDE*TEX_SIDE];
  bit           no_gaps;
  int           sent;

  bilinear_texel_tint_blend_unit uut (.*);

  bttb_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .pending, .covered_count, .shade_count
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure
  initial begin
    int g;
    out_tready = 1'b0;
    forever begin
      g = pick_gap();
      if (g > 0) begin
        out_tready = 1'b0;
        repeat (g) @(negedge clk);
      end
      out_tready = 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  // one request, held until taken, then an optional idle gap
  task automatic send_req(logic op, logic [103:0] data);
    int g;
    sent++;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = data;
    do @(posedge clk); while (!in_tready);
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic load_texel(logic [11:0] idx, logic [31:0] val);
    written[idx] = 1'b1;
    send_req(OP_LOAD, {4'd0, 32'd0, 12'd0, 12'd0, val, idx});
  endtask

  task automatic shade(logic [11:0] x, logic [11:0] y, logic [31:0] dest);
    send_req(OP_SHADE, {4'd0, dest, y, x, 32'd0, 12'd0});
  endtask

  // lets the pipe drain completely, then a margin for the register write
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (14) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = {idx, 3'b000};
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  function automatic int dim_of(int v);
    return (v < 3) ? 3 : (v > TEX_SIDE) ? TEX_SIDE : v;
  endfunction

  // how many texels along an axis can ever be read with these settings
  function automatic int reach(int org, int step, int dim, int cmax);
    longint maxdx, n;
    maxdx = ((cmax < 4096) ? cmax : 4096) - 1 - org;
    if (maxdx < 0) return 2;
    n = (maxdx * step) >> 16;
    if (n > dim - 2) n = dim - 2;
    return int'(n) + 2;
  endfunction

  // all eight registers, then loads for each texel the quad can touch that is not yet written
  task automatic set_regs(int o_x, int o_y, int s_x, int s_y, int w, int h,
                          int x0, int y0, int x1, int y1, logic [35:0] tint);
    int cols, rows;
    wait_idle();
    ox = o_x; oy = o_y; sx = s_x; sy = s_y; wd = w; ht = h;
    write_reg(REG_ORIGIN_X, 64'(o_x) & 64'h1fff);
    write_reg(REG_ORIGIN_Y, 64'(o_y) & 64'h1fff);
    write_reg(REG_STEP_X, 64'(s_x));
    write_reg(REG_STEP_Y, 64'(s_y));
    write_reg(REG_TEX_WIDTH, 64'(w));
    write_reg(REG_TEX_HEIGHT, 64'(h));
    write_reg(REG_CLIP_RECT, {16'd0, 12'(y1), 12'(x1), 12'(y0), 12'(x0)});
    write_reg(REG_TINT_RGBA, 64'(tint));
    cols = reach(o_x, s_x, dim_of(w & 127), x1);
    rows = reach(o_y, s_y, dim_of(h & 127), y1);
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        if (!written[r * TEX_SIDE + c]) load_texel(12'(r * TEX_SIDE + c), $urandom);
  endtask

  function automatic logic [35:0] rand_tint();
    logic [35:0] t;
    for (int k = 0; k < 4; k++)
      case ($urandom_range(0, 3))
        0: t[9*k +: 9] = 9'd256;
        1: t[9*k +: 9] = 9'($urandom_range(0, 511));
        2: t[9*k +: 9] = 9'($urandom_range(0, 256));
        default: t[9*k +: 9] = 9'($urandom_range(200, 256));
      endcase
    return t;
  endfunction

  // pixel coordinate near the quad along one axis, now and then anywhere
  function automatic logic [11:0] near_quad(int org, int step, int dim);
    int span;
    if ($urandom_range(0, 7) == 0) return 12'($urandom);
    span = (step == 0) ? 40 : ((dim - 1) << 16) / step;
    if (span > 200) span = 200;
    return 12'(org + $urandom_range(0, span + 3) - 2);
  endfunction

  initial begin
    int o_x, o_y, x0, y0, x1, y1, w, h;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_LOAD;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    no_gaps = 1'b0;
    sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // after reset the clip rectangle is empty: everything is clipped
    load_texel(12'hfff, 32'hffffffff);
    shade(12'd0, 12'd0, 32'h00000000);
    shade(12'hfff, 12'hfff, 32'hffffffff);

    // plain quad, full tint, pixels at the corner, edges and outside
    set_regs(10, 20, 16'h8000, 16'h8000, 8, 6, 0, 0, 4095, 4095, {4{9'd256}});
    shade(12'd10, 12'd20, 32'h80402010);
    shade(12'd9, 12'd20, 32'h12345678);
    shade(12'd10, 12'd19, 32'h12345678);
    shade(12'd22, 12'd28, 32'hffffffff);
    shade(12'd23, 12'd28, 32'h00000000);
    shade(12'd22, 12'd29, 32'h55aa55aa);
    shade(12'd15, 12'd23, 32'haa55aa55);

    // most negative origin, full step, sizes out of range, tints saturated
    set_regs(-4096, 0, 16'hffff, 16'hffff, 0, 127, 0, 0, 4095, 4095,
             {9'h1ff, 9'd0, 9'd257, 9'h1ff});
    shade(12'd0, 12'd0, 32'h01020304);
    shade(12'd1, 12'd1, 32'hfedcba98);
    shade(12'd0, 12'd62, 32'h7f7f7f7f);

    // zero step, largest origin, clip edges exclusive at the top end
    set_regs(4095, 4095, 0, 0, 64, 64, 4094, 4094, 4095, 4095, {4{9'd128}});
    shade(12'd4094, 12'd4094, 32'h11223344);
    shade(12'd4095, 12'd4095, 32'h11223344);
    set_regs(0, 0, 0, 16'h0100, 3, 3, 0, 0, 4095, 4095, 36'd0);
    shade(12'd4095, 12'd0, 32'h99887766);
    shade(12'd100, 12'd200, 32'h99887766);

    // full-size texture reached only near the corner
    set_regs(100, 100, 16'h2000, 16'h2000, 64, 64, 100, 100, 132, 132, rand_tint());
    shade(12'd100, 12'd100, 32'hcafef00d);
    shade(12'd131, 12'd131, 32'hdeadbeef);
    shade(12'd132, 12'd100, 32'hdeadbeef);

    // pause with the pipe drained before the random part
    wait_idle();

    while (sent < 450) begin
      case ($urandom_range(0, 9))
        0: begin o_x = -4096; o_y = 4095; end
        1: begin o_x = $urandom_range(0, 8191) - 4096; o_y = $urandom_range(0, 8191) - 4096; end
        default: begin o_x = $urandom_range(0, 300) - 100; o_y = $urandom_range(0, 300) - 100; end
      endcase
      w = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 127) : $urandom_range(3, 12);
      h = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 127) : $urandom_range(3, 12);
      case ($urandom_range(0, 5))
        0: begin x0 = 0; y0 = 0; x1 = 4095; y1 = 4095; end
        1: begin
          x0 = $urandom_range(0, 4095); y0 = $urandom_range(0, 4095);
          x1 = $urandom_range(0, 4095); y1 = $urandom_range(0, 4095);
        end
        default: begin
          x0 = (o_x > 0 ? o_x : 0) + $urandom_range(0, 10) - 5;
          y0 = (o_y > 0 ? o_y : 0) + $urandom_range(0, 10) - 5;
          if (x0 < 0) x0 = 0;
          if (y0 < 0) y0 = 0;
          x1 = x0 + $urandom_range(0, 300);
          y1 = y0 + $urandom_range(0, 300);
          if (x1 > 4095) x1 = 4095;
          if (y1 > 4095) y1 = 4095;
        end
      endcase
      set_regs(o_x, o_y, $urandom_range(0, 65535), $urandom_range(0, 65535), w, h,
               x0, y0, x1, y1, rand_tint());
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (55) begin
        if ($urandom_range(0, 4) == 0)
          load_texel(12'($urandom), $urandom);
        else
          shade(near_quad(ox, sx, dim_of(wd)), near_quad(oy, sy, dim_of(ht)), $urandom);
      end
      no_gaps = 1'b0;
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered: %0d shaded pixels of %0d written through the blend", covered_count,
             shade_count);
    $display("random settings for origin, step, texture size, clip and tint, with stalls");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
rtl/bttb_pkg.sv
rtl/bttb_map.sv
rtl/bttb_tex_mem.sv
rtl/bttb_filter.sv
rtl/bttb_blend.sv
rtl/bilinear_texel_tint_blend_unit.sv
sim/bttb_checker.sv
sim/tb_bilinear_texel_tint_blend_unit.sv
